// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check is clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ACM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition in one cycle implies an expression in the next cycle.
`define ACM_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- hdl/acm_pkg.sv -----
`timescale 1ns / 1ps

package acm_pkg;

	// Destinations that carry a live route; the others read as zero.
	localparam int CHANNELS = 8;

	localparam int NUM_SRC   = 8;
	localparam int NUM_DST   = 8;
	localparam int NUM_PAIRS = NUM_SRC / 2;
	localparam int SAMPLE_W  = 16;
	localparam int ROUTE_W   = 12;
	localparam int INDEX_W   = $clog2(NUM_DST);
	localparam int DIV_W     = 4;

	// Reciprocal scaling: quotient = (magnitude * recip) >> RECIP_SHIFT, exact for
	// every magnitude up to 2^15 and every divisor up to 15.
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_W     = 22;
	localparam int PROD_W      = SAMPLE_W + RECIP_W;

	typedef logic signed [SAMPLE_W-1:0]          sample_t;
	typedef logic [SAMPLE_W-1:0]                 mag_t;
	typedef logic [ROUTE_W-1:0]                  route_t;
	typedef logic [DIV_W-1:0]                    div_t;
	typedef logic [RECIP_W-1:0]                  recip_t;
	typedef logic [NUM_SRC-1:0][SAMPLE_W-1:0]    mag_vec_t;
	typedef logic [NUM_DST-1:0][SAMPLE_W-1:0]    mix_vec_t;

	// One finished frame on its way to the output buffer.
	typedef struct packed {
		mix_vec_t mixed;
		logic     last;
	} frame_t;

	// Rounded-up reciprocal of the divisor, scaled by 2^RECIP_SHIFT.
	function automatic recip_t recip(input div_t d);
		recip_t r;
		unique case (d)
			4'd1:    r = 22'd2097152;
			4'd2:    r = 22'd1048576;
			4'd3:    r = 22'd699051;
			4'd4:    r = 22'd524288;
			4'd5:    r = 22'd419431;
			4'd6:    r = 22'd349526;
			4'd7:    r = 22'd299594;
			4'd8:    r = 22'd262144;
			4'd9:    r = 22'd233017;
			4'd10:   r = 22'd209716;
			4'd11:   r = 22'd190651;
			4'd12:   r = 22'd174763;
			4'd13:   r = 22'd161320;
			4'd14:   r = 22'd149797;
			4'd15:   r = 22'd139811;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/acm_if.sv -----
`timescale 1ns / 1ps

// Source frame channel.
interface acm_in_if;
	logic             valid;
	logic             ready;
	acm_pkg::sample_t sample_0;
	acm_pkg::sample_t sample_1;
	acm_pkg::sample_t sample_2;
	acm_pkg::sample_t sample_3;
	acm_pkg::sample_t sample_4;
	acm_pkg::sample_t sample_5;
	acm_pkg::sample_t sample_6;
	acm_pkg::sample_t sample_7;
	logic             frame_last;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, sample_6, sample_7, frame_last, input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, sample_6, sample_7, frame_last, output ready);
endinterface

// Mixed frame channel.
interface acm_out_if;
	logic             valid;
	logic             ready;
	acm_pkg::sample_t mixed_0;
	acm_pkg::sample_t mixed_1;
	acm_pkg::sample_t mixed_2;
	acm_pkg::sample_t mixed_3;
	acm_pkg::sample_t mixed_4;
	acm_pkg::sample_t mixed_5;
	acm_pkg::sample_t mixed_6;
	acm_pkg::sample_t mixed_7;
	logic             frame_end;

	modport source (output valid, mixed_0, mixed_1, mixed_2, mixed_3, mixed_4,
		mixed_5, mixed_6, mixed_7, frame_end, input ready);
	modport sink (input valid, mixed_0, mixed_1, mixed_2, mixed_3, mixed_4,
		mixed_5, mixed_6, mixed_7, frame_end, output ready);
endinterface

// ----- hdl/audio_channel_matrix_mixer.sv -----
`timescale 1ns / 1ps
// Channel   Dir   Handshake        Payload
// src       in    valid / ready    sample_0..sample_7, frame_last
// mix       out   valid / ready    mixed_0..mixed_7, frame_end
// wr        in    wr_en            wr_index, wr_data (route registers)
//
// One item is taken per cycle while the output buffer is not full.
// The magnitude stage captures the item; registers after the reciprocal multipliers and
// after each of the two adder levels follow, and the output buffer register holds the result.
// Reset clears the route registers and all valid bits; payload flops are not reset.
// A stalled output fills a two-entry buffer; ready then drops and the pipeline holds.

`include "assert_macros.svh"

module audio_channel_matrix_mixer (
	input  logic                         clk,
	input  logic                         arst_n,
	acm_in_if.sink                       src,
	acm_out_if.source                    mix,
	input  logic                         wr_en,
	input  logic [acm_pkg::INDEX_W-1:0]  wr_index,
	input  acm_pkg::route_t              wr_data
);

	acm_pkg::route_t  route_q [acm_pkg::NUM_DST];
	acm_pkg::sample_t samp    [acm_pkg::NUM_SRC];

	acm_pkg::mag_vec_t           mag_s1;
	logic [acm_pkg::NUM_SRC-1:0] neg_s1;
	acm_pkg::mix_vec_t           mixed_s4;
	acm_pkg::frame_t             frame;

	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic en;

	// Route registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < acm_pkg::NUM_DST; d++) begin
				route_q[d] <= '0;
			end
		end else if (wr_en) begin
			route_q[wr_index] <= wr_data;
		end
	end

	assign samp[0] = src.sample_0;
	assign samp[1] = src.sample_1;
	assign samp[2] = src.sample_2;
	assign samp[3] = src.sample_3;
	assign samp[4] = src.sample_4;
	assign samp[5] = src.sample_5;
	assign samp[6] = src.sample_6;
	assign samp[7] = src.sample_7;

	assign src.ready = en;

	// Valid bits of the pipeline; every stage moves together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= src.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Sign and magnitude of every source, shared by all lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < acm_pkg::NUM_SRC; s++) begin
				neg_s1[s] <= samp[s][acm_pkg::SAMPLE_W-1];
				mag_s1[s] <= samp[s][acm_pkg::SAMPLE_W-1] ?
					acm_pkg::SAMPLE_W'(~samp[s] + 1'b1) : samp[s];
			end
			last_s1 <= src.frame_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
		end
	end

	// One lane per destination in use; the rest read as zero.
	for (genvar d = 0; d < acm_pkg::NUM_DST; d++) begin : g_lane
		if (d < acm_pkg::CHANNELS) begin : g_used
			acm_lane u_lane (
				.clk      (clk),
				.en       (en),
				.route    (route_q[d]),
				.mag_s1   (mag_s1),
				.neg_s1   (neg_s1),
				.mixed_s4 (mixed_s4[d])
			);
		end else begin : g_unused
			assign mixed_s4[d] = '0;
		end
	end

	assign frame.mixed = mixed_s4;
	assign frame.last  = last_s4;

	// Merge the lane results into one item and buffer it for the output.
	acm_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en & v_s4),
		.din    (frame),
		.en     (en),
		.mix    (mix)
	);

	// The pipeline stands still while the output buffer is full.
	`ACM_ASSERT_NEXT(a_hold_on_stall, !en, $stable(v_s2) && $stable(v_s3) && $stable(v_s4), "pipeline moved while stalled")
	// With an empty output buffer new items are always taken.
	`ACM_ASSERT(a_empty_takes, !mix.valid |-> src.ready, "ready low with empty output buffer")
	// A taken last frame enters the first stage with its marker.
	`ACM_ASSERT_NEXT(a_last_enters, src.valid && src.ready && src.frame_last, v_s1 && last_s1, "frame_last lost at entry")

endmodule

// ----- hdl/acm_lane.sv -----
`timescale 1ns / 1ps

// One destination lane: divides every routed source by the lane's divisor and
// sums the truncated terms over two adder stages.
module acm_lane (
	input  logic              clk,
	input  logic              en,
	input  acm_pkg::route_t   route,
	input  acm_pkg::mag_vec_t mag_s1,
	input  logic [acm_pkg::NUM_SRC-1:0] neg_s1,
	output acm_pkg::mag_t     mixed_s4
);

	acm_pkg::div_t   div;
	acm_pkg::recip_t rcp;
	logic [acm_pkg::NUM_SRC-1:0] mask;
	logic [acm_pkg::PROD_W-1:0]  prod [acm_pkg::NUM_SRC];
	acm_pkg::mag_t               term [acm_pkg::NUM_SRC];

	acm_pkg::mag_t               quot_s2 [acm_pkg::NUM_SRC];
	logic [acm_pkg::NUM_SRC-1:0] neg_s2;
	logic [acm_pkg::NUM_SRC-1:0] sel_s2;
	acm_pkg::mag_t               pair_s3 [acm_pkg::NUM_PAIRS];

	// Route fields and the divisor's reciprocal from the constant table.
	assign mask = route[acm_pkg::NUM_SRC-1:0];
	assign div  = route[acm_pkg::NUM_SRC +: acm_pkg::DIV_W];
	assign rcp  = acm_pkg::recip(div);

	// One multiplier per source replaces the division of the magnitude.
	always_comb begin
		for (int s = 0; s < acm_pkg::NUM_SRC; s++) begin
			prod[s] = acm_pkg::PROD_W'(mag_s1[s]) * acm_pkg::PROD_W'(rcp);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < acm_pkg::NUM_SRC; s++) begin
				quot_s2[s] <= prod[s][acm_pkg::RECIP_SHIFT +: acm_pkg::SAMPLE_W];
			end
			neg_s2 <= neg_s1;
			sel_s2 <= (div != '0) ? mask : '0;
		end
	end

	// Restore the sign of each quotient; an unselected source adds nothing.
	always_comb begin
		for (int s = 0; s < acm_pkg::NUM_SRC; s++) begin
			if (!sel_s2[s]) begin
				term[s] = '0;
			end else if (neg_s2[s]) begin
				term[s] = acm_pkg::SAMPLE_W'(~quot_s2[s] + 1'b1);
			end else begin
				term[s] = quot_s2[s];
			end
		end
	end

	// First adder level: pairs of terms, wrapping to 16 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < acm_pkg::NUM_PAIRS; p++) begin
				pair_s3[p] <= term[2*p] + term[2*p+1];
			end
		end
	end

	// Second adder level: sum of the pair sums.
	always_ff @(posedge clk) begin
		if (en) begin
			mixed_s4 <= pair_s3[0] + pair_s3[1] + pair_s3[2] + pair_s3[3];
		end
	end

endmodule

// ----- hdl/acm_outbuf.sv -----
`timescale 1ns / 1ps

// Two-entry output buffer. The pipeline keeps moving while one finished item
// waits; the upstream enable comes straight from a flop.
module acm_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  acm_pkg::frame_t din,
	output logic            en,
	acm_out_if.source       mix
);

	acm_pkg::frame_t main_q;
	acm_pkg::frame_t skid_q;
	logic            main_v_q;
	logic            skid_v_q;
	logic            pop;

	assign pop = main_v_q & mix.ready;
	assign en  = ~skid_v_q;

	// Valid bits of the two entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end
			main_v_q <= 1'b1;
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	// Payload of the two entries.
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_q <= din;
			end else begin
				skid_q <= din;
			end
		end
	end

	assign mix.valid     = main_v_q;
	assign mix.mixed_0   = main_q.mixed[0];
	assign mix.mixed_1   = main_q.mixed[1];
	assign mix.mixed_2   = main_q.mixed[2];
	assign mix.mixed_3   = main_q.mixed[3];
	assign mix.mixed_4   = main_q.mixed[4];
	assign mix.mixed_5   = main_q.mixed[5];
	assign mix.mixed_6   = main_q.mixed[6];
	assign mix.mixed_7   = main_q.mixed[7];
	assign mix.frame_end = main_q.last;

endmodule
